// File: hdl/top4ik_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the top-4 influence keep and normalize core.
// Used by top4ik_front, top4ik_back and the top level; depends on nothing.
package top4ik_pkg;

	// Default configuration of the store.
	localparam int MAX_VERTS_DEF = 4096;
	localparam int KEEP_DEF      = 4;
	localparam int BONE_BITS_DEF = 8;

	// Fixed field widths of the item and result ports.
	localparam int V_BITS    = 12;
	localparam int J_BITS    = 8;
	localparam int W_BITS    = 16;
	localparam int CNT_BITS  = 13;
	localparam int OUT_SLOTS = 4;
	localparam int SUM_BITS  = 18;
	localparam int V_SPAN    = 4096;

	// Action codes of an input item.
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	// One classified operation waiting in the queue.
	typedef struct packed {
		logic              rd;
		logic              ok;
		logic [V_BITS-1:0] v;
		logic [J_BITS-1:0] bone;
		logic [W_BITS-1:0] w;
	} op_t;

	// Queue head seen by the back part.
	typedef struct packed {
		logic valid;
		op_t  op;
	} link_t;

	// Handshake returned by the back part.
	typedef struct packed {
		logic pop;
		logic busy;
	} back_stat_t;

	// One result item.
	typedef struct packed {
		logic [V_BITS-1:0]                 v;
		logic [OUT_SLOTS-1:0][J_BITS-1:0]  joint;
		logic [OUT_SLOTS-1:0][W_BITS-1:0]  share;
	} res_t;

endpackage

// File: hdl/top4ik_front.sv
`timescale 1ns / 1ps
// Front part: accepts items, checks the range and weight, and queues work.
// Depends on top4ik_pkg.
module top4ik_front #(
	parameter int MAX_VERTS = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic                            action,
	input  logic [top4ik_pkg::V_BITS-1:0]   vertex_index,
	input  logic [top4ik_pkg::J_BITS-1:0]   bone_index,
	input  logic [top4ik_pkg::W_BITS-1:0]   influence_weight,
	input  logic [top4ik_pkg::CNT_BITS-1:0] vertex_count,
	input  top4ik_pkg::back_stat_t          stat,
	output top4ik_pkg::link_t               head
);
	import top4ik_pkg::*;

	localparam int DEPTH = (MAX_VERTS < V_SPAN) ? MAX_VERTS : V_SPAN;

	op_t        slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       in_range, keep_it, push;
	op_t        op_new;

	// Classify the incoming item.
	always_comb begin
		in_range = ({1'b0, vertex_index} < vertex_count) &&
			({1'b0, vertex_index} < CNT_BITS'(DEPTH));
		op_new.rd   = (action == ACT_READ);
		op_new.ok   = in_range;
		op_new.v    = vertex_index;
		op_new.bone = bone_index;
		op_new.w    = influence_weight;
		keep_it     = (action == ACT_READ) || (in_range && (influence_weight != '0));
	end

	assign item_ready = (cnt_q != 2'd2) && !stat.busy;
	assign push       = item_valid && item_ready && keep_it;

	// Two-entry queue between the front and the back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (stat.pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, stat.pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= op_new;
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.op    = slot_q[rp_q];

endmodule

// File: hdl/top4ik_back.sv
`timescale 1ns / 1ps
// Back part: influence store with clearing pass, insert update, shared divider.
// Depends on top4ik_pkg.
module top4ik_back #(
	parameter int MAX_VERTS = 4096,
	parameter int KEEP      = 4,
	parameter int BONE_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  top4ik_pkg::link_t head,
	output top4ik_pkg::back_stat_t stat,
	output logic              res_valid,
	input  logic              res_ready,
	output top4ik_pkg::res_t  res
);
	import top4ik_pkg::*;

	localparam int DEPTH = (MAX_VERTS < V_SPAN) ? MAX_VERTS : V_SPAN;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int N     = (KEEP < OUT_SLOTS) ? KEEP : OUT_SLOTS;
	localparam int SL    = (KEEP > OUT_SLOTS) ? KEEP : OUT_SLOTS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXE  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_OUT  = 3'd3;

	logic [KEEP-1:0][BONE_BITS-1:0] kb_mem [DEPTH];
	logic [KEEP-1:0][W_BITS-1:0]    kw_mem [DEPTH];
	logic [KEEP-1:0][BONE_BITS-1:0] rb_q;
	logic [KEEP-1:0][W_BITS-1:0]    rw_q;

	logic [2:0]    st_q;
	logic          busy_q;
	logic [AW-1:0] clr_q;
	op_t           op_q;

	logic [OUT_SLOTS-1:0][W_BITS-1:0] wq_q;
	logic [OUT_SLOTS-1:0][J_BITS-1:0] bq_q;
	logic [OUT_SLOTS-1:0][W_BITS-1:0] sh_q;
	logic [SUM_BITS-1:0] sum_q;
	logic [SUM_BITS:0]   rem_q;
	logic [W_BITS-1:0]   nlo_q;
	logic [W_BITS-1:0]   quo_q;
	logic [1:0]          k_q;
	logic [3:0]          cnt_q;
	logic                ov_q;
	res_t                res_q;

	logic                           pop, mem_we;
	logic [AW-1:0]                  mem_wa;
	logic [KEEP-1:0]                gt;
	logic [KEEP-1:0][BONE_BITS-1:0] nb;
	logic [KEEP-1:0][W_BITS-1:0]    nw;
	logic [SL-1:0][W_BITS-1:0]      rwx;
	logic [SL-1:0][BONE_BITS-1:0]   rbx;
	logic [SUM_BITS-1:0]            sum;
	logic [SUM_BITS:0]              trial;
	logic [SUM_BITS:0]              trial_sub;
	logic                           qbit;
	logic                           out_free;
	logic [W_BITS-1:0]              wsel;
	logic [31:0]                    numer;

	assign pop       = (st_q == S_IDLE) && head.valid && !busy_q;
	assign stat.pop  = pop;
	assign stat.busy = busy_q;
	assign out_free  = !ov_q || res_ready;

	// Insert: the new influence goes before the first strictly lighter one.
	always_comb begin
		for (int k = 0; k < KEEP; k++) begin
			gt[k] = op_q.w > rw_q[k];
		end
		nw[0] = gt[0] ? op_q.w : rw_q[0];
		nb[0] = gt[0] ? BONE_BITS'(op_q.bone) : rb_q[0];
		for (int k = 1; k < KEEP; k++) begin
			if (!gt[k]) begin
				nw[k] = rw_q[k];
				nb[k] = rb_q[k];
			end else if (!gt[k-1]) begin
				nw[k] = op_q.w;
				nb[k] = BONE_BITS'(op_q.bone);
			end else begin
				nw[k] = rw_q[k-1];
				nb[k] = rb_q[k-1];
			end
		end
	end

	// Read: first four slots and their sum.
	always_comb begin
		rwx = '0;
		rbx = '0;
		rwx[KEEP-1:0] = rw_q;
		rbx[KEEP-1:0] = rb_q;
		sum = '0;
		for (int k = 0; k < OUT_SLOTS; k++) begin
			sum = sum + SUM_BITS'(rwx[k]);
		end
	end

	// Memory write port: clearing pass or insert update.
	assign mem_we = busy_q || ((st_q == S_EXE) && !op_q.rd);
	assign mem_wa = busy_q ? clr_q : op_q.v[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			kb_mem[mem_wa] <= busy_q ? '0 : nb;
			kw_mem[mem_wa] <= busy_q ? '0 : nw;
		end
		if (pop) begin
			rb_q <= kb_mem[head.op.v[AW-1:0]];
			rw_q <= kw_mem[head.op.v[AW-1:0]];
		end
	end

	// Divider step: one quotient bit per cycle.
	always_comb begin
		trial     = {rem_q[SUM_BITS-1:0], nlo_q[W_BITS-1]};
		trial_sub = trial - {1'b0, sum_q};
		qbit      = (trial >= {1'b0, sum_q});
	end

	// Numerator for the next slot: w * 32768 + sum / 2.
	always_comb begin
		wsel  = (st_q == S_EXE) ? rwx[0] : wq_q[k_q + 2'd1];
		numer = {1'b0, wsel, 15'd0} + 32'(st_q == S_EXE ? sum : sum_q) / 2;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			busy_q <= 1'b1;
			clr_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == AW'(DEPTH - 1)) busy_q <= 1'b0;
			end
			if (ov_q && res_ready) ov_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (pop) st_q <= S_EXE;
				end
				S_EXE: begin
					if (!op_q.rd) st_q <= S_IDLE;
					else if (!op_q.ok || sum == '0) st_q <= S_OUT;
					else st_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == 4'd15 && k_q == 2'(N - 1)) st_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						ov_q <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		if (pop) op_q <= head.op;
		case (st_q)
			S_EXE: begin
				sh_q  <= '0;
				bq_q  <= '0;
				k_q   <= '0;
				cnt_q <= '0;
				sum_q <= sum;
				rem_q <= {3'd0, numer[31:16]};
				nlo_q <= numer[15:0];
				for (int k = 0; k < OUT_SLOTS; k++) begin
					wq_q[k] <= rwx[k];
					if (op_q.ok && sum != '0) bq_q[k] <= J_BITS'(rbx[k]);
				end
			end
			S_DIV: begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					sh_q[k_q] <= {quo_q[W_BITS-2:0], qbit};
					k_q       <= k_q + 2'd1;
					rem_q     <= {3'd0, numer[31:16]};
					nlo_q     <= numer[15:0];
				end else begin
					rem_q <= qbit ? trial_sub : trial;
					nlo_q <= {nlo_q[W_BITS-2:0], 1'b0};
				end
				quo_q <= {quo_q[W_BITS-2:0], qbit};
			end
			S_OUT: begin
				if (out_free) begin
					res_q.v     <= op_q.v;
					res_q.joint <= bq_q;
					res_q.share <= sh_q;
				end
			end
			default: ;
		endcase
	end

	assign res_valid = ov_q;
	assign res       = res_q;

endmodule

// File: hdl/top4ik_influence_keep_normalize_core.sv
`timescale 1ns / 1ps
// Top level of the top-4 influence keep and normalize core: APB register,
// front and back parts. Depends on top4ik_pkg, top4ik_front and top4ik_back.
//
//  Channel  | Handshake                          | Payload
//  ---------+------------------------------------+----------------------------------
//  item     | item_valid / item_ready            | action, vertex_index, bone_index,
//           |                                    | influence_weight
//  result   | result_valid / result_ready        | vertex_echo, joint_a..d, share_a..d
//  config   | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// An insert is read from memory when the back part pops it, then updated and
// written back in S_EXE. The back part pops a new operation only when idle. A read
// passes the memory read, S_EXE, S_DIV for each of the min(KEEP, 4) slots on the
// shared one-bit-per-cycle divider, and S_OUT; out-of-range and empty reads skip
// S_DIV. After reset a clearing pass zeroes all min(MAX_VERTS, 4096) entries; items
// wait. A two-entry queue lets the front take items while the back works or stalls.
module top4_influence_keep_normalize_core #(
	parameter int MAX_VERTS = top4ik_pkg::MAX_VERTS_DEF,
	parameter int KEEP      = top4ik_pkg::KEEP_DEF,
	parameter int BONE_BITS = top4ik_pkg::BONE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic                          action,
	input  logic [top4ik_pkg::V_BITS-1:0] vertex_index,
	input  logic [top4ik_pkg::J_BITS-1:0] bone_index,
	input  logic [top4ik_pkg::W_BITS-1:0] influence_weight,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [top4ik_pkg::V_BITS-1:0] vertex_echo,
	output logic [top4ik_pkg::J_BITS-1:0] joint_a,
	output logic [top4ik_pkg::J_BITS-1:0] joint_b,
	output logic [top4ik_pkg::J_BITS-1:0] joint_c,
	output logic [top4ik_pkg::J_BITS-1:0] joint_d,
	output logic [top4ik_pkg::W_BITS-1:0] share_a,
	output logic [top4ik_pkg::W_BITS-1:0] share_b,
	output logic [top4ik_pkg::W_BITS-1:0] share_c,
	output logic [top4ik_pkg::W_BITS-1:0] share_d
);
	import top4ik_pkg::*;

	localparam logic REG_VCOUNT = 1'b0;

	logic [CNT_BITS-1:0] vcount_q;
	link_t               head;
	back_stat_t          stat;
	res_t                res;

	// Configuration register; byte address 4 and up hold nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_VCOUNT) begin
			vcount_q <= pwdata[CNT_BITS-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_VCOUNT) ? 32'(vcount_q) : 32'd0;

	top4ik_front #(
		.MAX_VERTS(MAX_VERTS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_ready       (item_ready),
		.action           (action),
		.vertex_index     (vertex_index),
		.bone_index       (bone_index),
		.influence_weight (influence_weight),
		.vertex_count     (vcount_q),
		.stat             (stat),
		.head             (head)
	);

	top4ik_back #(
		.MAX_VERTS (MAX_VERTS),
		.KEEP      (KEEP),
		.BONE_BITS (BONE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.res_valid (result_valid),
		.res_ready (result_ready),
		.res       (res)
	);

	// Split the result transfer into its fields.
	assign vertex_echo = res.v;
	assign joint_a     = res.joint[0];
	assign joint_b     = res.joint[1];
	assign joint_c     = res.joint[2];
	assign joint_d     = res.joint[3];
	assign share_a     = res.share[0];
	assign share_b     = res.share[1];
	assign share_c     = res.share[2];
	assign share_d     = res.share[3];

endmodule
